### design/tkd_pkg.sv
`default_nettype none

package tkd_pkg;

  // Input op codes (carried on tuser)
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_NONE = 2'd1;
  localparam logic [1:0] OP_EOI  = 2'd2;

  // Result key kinds
  localparam logic [3:0] KIND_PLAIN      = 4'd0;
  localparam logic [3:0] KIND_HOME       = 4'd1;
  localparam logic [3:0] KIND_END        = 4'd2;
  localparam logic [3:0] KIND_DELETE     = 4'd3;
  localparam logic [3:0] KIND_UP         = 4'd4;
  localparam logic [3:0] KIND_DOWN       = 4'd5;
  localparam logic [3:0] KIND_LEFT       = 4'd6;
  localparam logic [3:0] KIND_RIGHT      = 4'd7;
  localparam logic [3:0] KIND_CTRL_LEFT  = 4'd8;
  localparam logic [3:0] KIND_CTRL_RIGHT = 4'd9;
  localparam logic [3:0] KIND_BARE_ESC   = 4'd10;
  localparam logic [3:0] KIND_EOI        = 4'd11;

  // Characters
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;  // '['
  localparam logic [7:0] CH_O      = 8'h4f;  // 'O'
  localparam logic [7:0] CH_TILDE  = 8'h7e;  // '~'
  localparam logic [7:0] CH_SEMI   = 8'h3b;  // ';'
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;

  // Decode result for one item
  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic [7:0] key_byte;
  } tkd_res_t;

endpackage

`default_nettype wire

### design/tkd_decoder.sv
`default_nettype none

// Escape sequence state machine. res is combinational from the current
// state and the item; state advances only when step is high.
module tkd_decoder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [1:0]       op,
  input  wire logic [7:0]       data_byte,
  output tkd_pkg::tkd_res_t     res
);
  import tkd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_INTRO = 3'd2,
    PH_DIGIT = 3'd3,
    PH_MOD   = 3'd4,
    PH_FINAL = 3'd5
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] intro_r, intro_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic       mod5_r, mod5_nxt;
  logic       have;
  logic [3:0] k;

  assign have = (op == OP_DATA);

  always_comb begin
    phase_nxt = phase_r;
    intro_nxt = intro_r;
    digit_nxt = digit_r;
    mod5_nxt  = mod5_r;
    res       = '0;
    k         = KIND_PLAIN;
    case (phase_r)
      PH_ESC: begin
        if (!have) begin
          phase_nxt = PH_IDLE;
          res       = '{emit: 1'b1, kind: KIND_BARE_ESC, key_byte: CH_ESC};
        end else begin
          intro_nxt = data_byte;
          phase_nxt = PH_INTRO;
        end
      end
      PH_INTRO: begin
        phase_nxt = PH_IDLE;
        if (!have) begin
          res = '{emit: 1'b1, kind: KIND_BARE_ESC, key_byte: CH_ESC};
        end else if (intro_r == CH_LBRACK && data_byte >= CH_0 && data_byte <= CH_9) begin
          digit_nxt = data_byte;
          phase_nxt = PH_DIGIT;
        end else begin
          if (intro_r == CH_LBRACK) begin
            case (data_byte)
              CH_A:    k = KIND_UP;
              CH_B:    k = KIND_DOWN;
              CH_C:    k = KIND_RIGHT;
              CH_D:    k = KIND_LEFT;
              CH_H:    k = KIND_HOME;
              CH_F:    k = KIND_END;
              default: k = KIND_PLAIN;
            endcase
          end else if (intro_r == CH_O) begin
            case (data_byte)
              CH_H:    k = KIND_HOME;
              CH_F:    k = KIND_END;
              default: k = KIND_PLAIN;
            endcase
          end
          res = '{emit: (k != KIND_PLAIN), kind: k, key_byte: 8'd0};
        end
      end
      PH_DIGIT: begin
        phase_nxt = PH_IDLE;
        if (!have) begin
          res = '{emit: 1'b1, kind: KIND_BARE_ESC, key_byte: CH_ESC};
        end else if (data_byte == CH_SEMI) begin
          phase_nxt = PH_MOD;
        end else begin
          if (data_byte == CH_TILDE) begin
            case (digit_r)
              CH_1, CH_7: k = KIND_HOME;
              CH_3:       k = KIND_DELETE;
              CH_4, CH_8: k = KIND_END;
              default:    k = KIND_PLAIN;
            endcase
          end
          res = '{emit: (k != KIND_PLAIN), kind: k, key_byte: 8'd0};
        end
      end
      PH_MOD: begin
        if (!have) begin
          phase_nxt = PH_IDLE;  // late break: swallowed
        end else begin
          mod5_nxt  = (data_byte == CH_5);
          phase_nxt = PH_FINAL;
        end
      end
      PH_FINAL: begin
        phase_nxt = PH_IDLE;
        if (have && mod5_r) begin
          case (data_byte)
            CH_C:    k = KIND_CTRL_RIGHT;
            CH_D:    k = KIND_CTRL_LEFT;
            default: k = KIND_PLAIN;
          endcase
        end
        res = '{emit: (k != KIND_PLAIN), kind: k, key_byte: 8'd0};
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (op == OP_EOI) begin
          res = '{emit: 1'b1, kind: KIND_EOI, key_byte: 8'd0};
        end else if (have) begin
          if (data_byte == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            res = '{emit: 1'b1, kind: KIND_PLAIN, key_byte: data_byte};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      intro_r <= 8'd0;
      digit_r <= 8'd0;
      mod5_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      intro_r <= intro_nxt;
      digit_r <= digit_nxt;
      mod5_r  <= mod5_nxt;
    end
  end

endmodule

`default_nettype wire

### design/terminal_key_escape_decoder.sv
// Path: an accepted item is held in the input register, decoded, and its
// key is written to the result register once that slot is free.
// Throughput: 1 transaction per cycle while out_tready is high; keyless
// items retire even when a result is held, a key-producing item waits and
// drops in_tready until the slot drains. Reset: rst_n synchronous, active
// low; decoder returns to idle, both pipeline registers empty.
`default_nettype none

module terminal_key_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic [1:0] in_tuser,   // [1:0] op
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] key_byte
  output logic [3:0]      out_tuser   // [3:0] key_kind
);
  import tkd_pkg::*;

  // Input register stage
  logic       in_valid_r;
  logic [1:0] in_op_r;
  logic [7:0] in_byte_r;

  // Result register stage
  logic       out_valid_r;
  logic [3:0] out_kind_r;
  logic [7:0] out_byte_r;

  tkd_res_t res;
  logic     adv;   // item in the input register is decoded this cycle
  logic     out_free;

  // Decoder state moves only when the registered item is consumed.
  tkd_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .res       (res)
  );

  // Result slot is usable if empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  // Items that produce no key retire regardless of output backpressure.
  assign adv       = in_valid_r && (!res.emit || out_free);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.key_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_byte_r;

endmodule

`default_nettype wire

### tb/sv/tb_terminal_key_escape_decoder.sv
`default_nettype none

module tb_terminal_key_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  // op value 3 is not a defined code; the decoder must treat it as "no data"
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int N_RANDOM   = 900;  // random input transactions after the directed table
  localparam int HOLD_AT    = 350;  // transaction count where the long output hold-off starts
  localparam int HOLD_LEN   = 120;  // cycles out_tready stays low during the hold-off
  localparam int CALM_AT    = 800;  // from here on neither side idles
  localparam int DRAIN_WAIT = 8;    // wait after the key queue empties, to catch stray keys

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0] in_tuser = OP_NONE; // [1:0] op
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] key_byte
  logic [3:0] out_tuser;          // [3:0] key_kind

  terminal_key_escape_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Types and shared state
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] kb;
  } keypress_t;

  // A directed row may pin its expected key; otherwise the decoder model decides.
  typedef struct packed {
    logic      has;
    keypress_t key;
  } pinned_t;

  typedef struct packed {
    item_t   it;
    pinned_t pin;
  } dir_row_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_INTRO, ST_DIGIT, ST_MOD, ST_FINAL
  } esc_state_t;

  keypress_t  key_q[$];     // keys still owed by the DUT, oldest first
  pinned_t    pin_q[$];     // per offered transaction, in offer order
  int         errors = 0;
  int         sent = 0;     // input transactions accepted so far
  bit         calm = 1'b0;  // set near the end: no idling on either side
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  // Decoder model state
  esc_state_t dec_state = ST_IDLE;
  logic [7:0] dec_intro = 8'h00;
  logic [7:0] dec_digit = 8'h00;
  logic       dec_mod5 = 1'b0;

  // --------------------------------------------------------------------------
  // Decoder model: one input transaction in, at most one keypress out
  // --------------------------------------------------------------------------
  function automatic void decode_key(input logic [1:0] op, input logic [7:0] b,
                                     output logic hit, output keypress_t key);
    logic       have;
    logic [3:0] k;
    hit  = 1'b0;
    key  = '{kind: KIND_PLAIN, kb: 8'h00};
    have = (op == OP_DATA);
    k    = KIND_PLAIN;  // PLAIN here means "nothing recognized, swallow"

    // markers: early break gives a bare ESC, late break is silent
    case (dec_state)
      ST_ESC, ST_INTRO, ST_DIGIT: begin
        if (!have) begin
          dec_state = ST_IDLE;
          hit = 1'b1;
          key = '{kind: KIND_BARE_ESC, kb: CH_ESC};
          return;
        end
      end
      ST_MOD, ST_FINAL: begin
        if (!have) begin
          dec_state = ST_IDLE;
          return;
        end
      end
      default: begin
        dec_state = ST_IDLE;
        if (op == OP_EOI) begin
          hit = 1'b1;
          key = '{kind: KIND_EOI, kb: 8'h00};
        end else if (have && b != CH_ESC) begin
          hit = 1'b1;
          key = '{kind: KIND_PLAIN, kb: b};
        end else if (have) begin
          dec_state = ST_ESC;
        end
        return;
      end
    endcase

    case (dec_state)
      ST_ESC: begin
        dec_intro = b;
        dec_state = ST_INTRO;
      end
      ST_INTRO: begin
        dec_state = ST_IDLE;
        if (dec_intro == CH_LBRACK) begin
          if (b >= CH_0 && b <= CH_9) begin
            dec_digit = b;
            dec_state = ST_DIGIT;
          end else begin
            case (b)
              CH_A: k = KIND_UP;
              CH_B: k = KIND_DOWN;
              CH_C: k = KIND_RIGHT;
              CH_D: k = KIND_LEFT;
              CH_H: k = KIND_HOME;
              CH_F: k = KIND_END;
              default: k = KIND_PLAIN;
            endcase
          end
        end else if (dec_intro == CH_O) begin
          if (b == CH_H) k = KIND_HOME;
          else if (b == CH_F) k = KIND_END;
        end
      end
      ST_DIGIT: begin
        dec_state = ST_IDLE;
        if (b == CH_SEMI) begin
          dec_state = ST_MOD;
        end else if (b == CH_TILDE) begin
          if (dec_digit == CH_1 || dec_digit == CH_7) k = KIND_HOME;
          else if (dec_digit == CH_3) k = KIND_DELETE;
          else if (dec_digit == CH_4 || dec_digit == CH_8) k = KIND_END;
        end
      end
      ST_MOD: begin
        dec_mod5  = (b == CH_5);
        dec_state = ST_FINAL;
      end
      default: begin  // ST_FINAL
        dec_state = ST_IDLE;
        if (dec_mod5) begin
          if (b == CH_C) k = KIND_CTRL_RIGHT;
          else if (b == CH_D) k = KIND_CTRL_LEFT;
        end
      end
    endcase

    if (k != KIND_PLAIN) begin
      hit = 1'b1;
      key = '{kind: k, kb: 8'h00};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on input transactions, check on output transactions.
  // Reads happen in the active region at the edge, so they see the values
  // that the DUT registered on.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pinned_t   pin;
    keypress_t want;
    logic      hit;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sent++;
        pin = pin_q.pop_front();
        decode_key(in_tuser, in_tdata, hit, want);
        if (pin.has) begin
          hit  = 1'b1;
          want = pin.key;
        end
        if (hit) key_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (key_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected key: got kind %0d byte 0x%02h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = key_q.pop_front();
          if (out_tuser !== want.kind) begin
            errors++;
            $display("%0t: key_kind mismatch: expected %0d, got %0d",
                     $time, want.kind, out_tuser);
          end
          if (out_tdata !== want.kb) begin
            errors++;
            $display("%0t: key_byte mismatch: expected 0x%02h, got 0x%02h",
                     $time, want.kb, out_tdata);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random ready bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_cnt;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long stall so the output register fills and in_tready drops
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_LEN; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one transaction and return at the edge where it was taken.
  // tvalid stays high between back-to-back items (no low/high in one step).
  task automatic send_item(input item_t it, input pinned_t pin);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pin_q.push_back(pin);
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= it.b;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t marker();
    item_t m;
    case ($urandom_range(0, 2))
      0: m.op = OP_NONE;
      1: m.op = OP_EOI;
      default: m.op = OP_SPARE;
    endcase
    m.b = any_byte();  // ignored by the block, toggled anyway
    return m;
  endfunction

  function automatic item_t data(input logic [7:0] b);
    return '{op: OP_DATA, b: b};
  endfunction

  localparam logic [7:0] CSI_FINALS[6]  = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
  localparam logic [7:0] TILDE_DIGITS[5] = '{CH_1, CH_7, CH_3, CH_4, CH_8};

  // Build one burst of input: mostly well-formed key sequences with random
  // content, sometimes cut short by a marker, plus idle markers and noise.
  task automatic send_burst();
    item_t      burst[$];
    item_t      it;
    logic [7:0] b;
    int         cut;
    int         n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin  // plain byte
        b = any_byte();
        burst.push_back(data(b == CH_ESC ? ~b : b));
      end
      3: begin  // ESC [ final
        burst.push_back(data(CH_ESC));
        burst.push_back(data(CH_LBRACK));
        burst.push_back(data($urandom_range(0, 4) != 0 ?
                             CSI_FINALS[$urandom_range(0, 5)] : any_byte()));
      end
      4: begin  // ESC O final
        burst.push_back(data(CH_ESC));
        burst.push_back(data(CH_O));
        b = $urandom_range(0, 1) ? CH_H : CH_F;
        burst.push_back(data($urandom_range(0, 3) != 0 ? b : any_byte()));
      end
      5: begin  // ESC [ digit ~
        burst.push_back(data(CH_ESC));
        burst.push_back(data(CH_LBRACK));
        b = $urandom_range(0, 3) != 0 ? TILDE_DIGITS[$urandom_range(0, 4)]
                                      : 8'(CH_0 + $urandom_range(0, 9));
        burst.push_back(data(b));
        burst.push_back(data($urandom_range(0, 6) != 0 ? CH_TILDE : any_byte()));
      end
      6: begin  // ESC [ digit ; modifier final
        burst.push_back(data(CH_ESC));
        burst.push_back(data(CH_LBRACK));
        burst.push_back(data(8'(CH_0 + $urandom_range(0, 9))));
        burst.push_back(data($urandom_range(0, 7) != 0 ? CH_SEMI : any_byte()));
        burst.push_back(data($urandom_range(0, 4) != 0 ? CH_5 : any_byte()));
        b = $urandom_range(0, 1) ? CH_C : CH_D;
        burst.push_back(data($urandom_range(0, 4) != 0 ? b : any_byte()));
      end
      7: begin  // ESC with arbitrary intro and follow-up
        burst.push_back(data(CH_ESC));
        burst.push_back(data(any_byte()));
        burst.push_back(data(any_byte()));
      end
      8: begin  // marker while idle
        burst.push_back(marker());
      end
      default: begin  // noise, ESC-heavy
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 7))
            5: it.op = OP_NONE;
            6: it.op = OP_EOI;
            7: it.op = OP_SPARE;
            default: it.op = OP_DATA;
          endcase
          it.b = $urandom_range(0, 3) == 0 ? CH_ESC : any_byte();
          burst.push_back(it);
        end
      end
    endcase

    // break a sequence early or late with a marker in place of a byte
    if (burst.size() > 1 && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, burst.size() - 1);
      burst = burst[0:cut-1];
      burst.push_back(marker());
    end

    foreach (burst[i]) send_item(burst[i], '{has: 1'b0, key: '0});
  endtask

  // Directed table: extremes, each op, a few full sequences and both kinds
  // of early break. Rows with an obvious answer carry it pinned.
  localparam pinned_t FREE = '{has: 1'b0, key: '0};
  localparam dir_row_t DIR_TAB[25] = '{
    // end of input and no-data while idle
    '{it: '{OP_EOI,  8'h00}, pin: '{1'b1, '{KIND_EOI, 8'h00}}},
    '{it: '{OP_NONE, 8'h5a}, pin: FREE},
    // plain byte extremes
    '{it: '{OP_DATA, 8'h00}, pin: '{1'b1, '{KIND_PLAIN, 8'h00}}},
    '{it: '{OP_DATA, 8'hff}, pin: '{1'b1, '{KIND_PLAIN, 8'hff}}},
    // ESC [ A
    '{it: '{OP_DATA, CH_ESC},    pin: FREE},
    '{it: '{OP_DATA, CH_LBRACK}, pin: FREE},
    '{it: '{OP_DATA, CH_A},      pin: FREE},
    // ESC O H
    '{it: '{OP_DATA, CH_ESC}, pin: FREE},
    '{it: '{OP_DATA, CH_O},   pin: FREE},
    '{it: '{OP_DATA, CH_H},   pin: FREE},
    // ESC [ 3 ~
    '{it: '{OP_DATA, CH_ESC},    pin: FREE},
    '{it: '{OP_DATA, CH_LBRACK}, pin: FREE},
    '{it: '{OP_DATA, CH_3},      pin: FREE},
    '{it: '{OP_DATA, CH_TILDE},  pin: FREE},
    // ESC [ 5 ; 5 C
    '{it: '{OP_DATA, CH_ESC},    pin: FREE},
    '{it: '{OP_DATA, CH_LBRACK}, pin: FREE},
    '{it: '{OP_DATA, CH_5},      pin: FREE},
    '{it: '{OP_DATA, CH_SEMI},   pin: FREE},
    '{it: '{OP_DATA, CH_5},      pin: FREE},
    '{it: '{OP_DATA, CH_C},      pin: FREE},
    // no data right after ESC: bare escape
    '{it: '{OP_DATA, CH_ESC}, pin: FREE},
    '{it: '{OP_NONE, 8'ha5},  pin: '{1'b1, '{KIND_BARE_ESC, CH_ESC}}},
    // end of input after the intro byte: bare escape
    '{it: '{OP_DATA, CH_ESC},    pin: FREE},
    '{it: '{OP_DATA, CH_LBRACK}, pin: FREE},
    '{it: '{OP_EOI,  8'h3c},     pin: '{1'b1, '{KIND_BARE_ESC, CH_ESC}}}
  };

  initial begin : stimulus
    int total;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) send_item(DIR_TAB[i].it, DIR_TAB[i].pin);

    total = $size(DIR_TAB) + N_RANDOM;
    while (sent < total) begin
      // one long hold-off, whatever count the last burst ended on
      if (sent >= HOLD_AT && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (sent >= CALM_AT) calm = 1'b1;
      send_burst();
    end
    in_tvalid <= 1'b0;
    calm = 1'b1;

    while (key_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && key_q.size() == 0) begin
      $display("** terminal_key_escape_decoder: PASSED **");
    end else begin
      $display("** terminal_key_escape_decoder: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("** terminal_key_escape_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

### terminal_key_escape_decoder.f
design/tkd_pkg.sv
design/tkd_decoder.sv
design/terminal_key_escape_decoder.sv
tb/sv/tb_terminal_key_escape_decoder.sv
